### design/tcache_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcache_pkg
// shared entry type and command / status codes of the texture tag cache
// ----------------------------------------------------------------------------
package tcache_pkg;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FRAME  = 2'd1;
    localparam logic [1:0] CMD_DIRTY  = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_HIT      = 3'd1;
    localparam logic [2:0] ST_RELOAD   = 3'd2;
    localparam logic [2:0] ST_FILL     = 3'd3;
    localparam logic [2:0] ST_REPLACED = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE = 3'd5;
    localparam logic [2:0] ST_ALL_LIVE = 3'd6;

    typedef struct packed {
        logic [31:0] guest_address;
        logic [63:0] host_handle;
        logic        keyed;
        logic [31:0] key_low;
        logic [31:0] key_high;
        logic [13:0] width;
        logic [13:0] height;
        logic [31:0] hash;
        logic        dirty;
        logic [63:0] used_frame;
    } entry_t;

endpackage

### design/texture_tag_cache_lru_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_tag_cache_lru_frame
// fully associative surface tag store with per-frame lru replacement
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with cmd and key fields, one word per
//   command; output channel: out_valid / out_stall with status and slot,
//   exactly one word per command
//   entries live in a ring of CAPACITY cells that rotates by one cell per
//   cycle while a command is scanned or an entry replaced; the compare and
//   update logic sits at the head of the ring
//   a lookup, a dirty mark and a frame wrap take one full rotation; a
//   lookup that replaces an entry takes a second rotation to write the victim
//   bad size, an unused command and a begin frame without wrap skip the
//   rotation and go straight to the hold state
//   one command is worked at a time: in_stall is high while busy
//   a result waits in the output register while out_stall is high; the
//   next command is taken meanwhile and finishes into a hold state
//   reset clears the state, the fill count, the frame counter and out_valid;
//   entry contents are not reset and only filled entries are ever read
// ----------------------------------------------------------------------------
module texture_tag_cache_lru_frame
#(
    parameter int CAPACITY = 512
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic        is_host,
    input  logic [63:0] source_address,
    input  logic [13:0] width,
    input  logic [13:0] height,
    input  logic        keyed,
    input  logic [31:0] key_low,
    input  logic [31:0] key_high,
    input  logic [31:0] content_hash,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [8:0]  slot
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_REPL = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [63:0]   frame_reg, frame_next;

    // latched command word
    logic [1:0]  cmd_reg;
    logic        host_reg;
    logic [63:0] addr_reg;
    logic [13:0] w_reg;
    logic [13:0] h_reg;
    logic        keyed_reg;
    logic [31:0] klo_reg;
    logic [31:0] khi_reg;
    logic [31:0] hash_reg;

    // scan bookkeeping
    logic          resolved_reg, resolved_next;
    logic          found_reg, found_next;
    logic [63:0]   best_reg, best_next;
    logic [IW-1:0] victim_reg, victim_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic [IW-1:0] res_slot_reg, res_slot_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    status_reg, status_next;
    logic [IW-1:0] slot_reg, slot_next;

    // ring of cells, cell 0 is the head
    tcache_pkg::entry_t ring_q [CAPACITY];
    tcache_pkg::entry_t head_mod;
    tcache_pkg::entry_t new_entry;
    logic               shift;

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_ring
            if (k == CAPACITY - 1)
            begin : g_tail
                tcache_cell u_cell
                (
                    .clk       (clk),
                    .shift     (shift),
                    .entry_in  (head_mod),
                    .entry_out (ring_q[k])
                );
            end
            else
            begin : g_mid
                tcache_cell u_cell
                (
                    .clk       (clk),
                    .shift     (shift),
                    .entry_in  (ring_q[k+1]),
                    .entry_out (ring_q[k])
                );
            end
        end
    endgenerate

    logic accept;
    logic live;
    logic key_hit;
    logic last_step;
    logic [63:0] frame_inc;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign shift     = (state_reg == S_SCAN) || (state_reg == S_REPL);
    assign last_step = (idx_reg == LAST_IDX);
    assign live      = (CW'(idx_reg) < count_reg);
    assign frame_inc = frame_reg + 64'd1;

    // key compare against the head entry
    always_comb
    begin
        key_hit = (ring_q[0].width == w_reg) && (ring_q[0].height == h_reg)
               && (ring_q[0].keyed == keyed_reg);
        if (host_reg)
        begin
            key_hit = key_hit && (ring_q[0].host_handle == addr_reg);
        end
        else
        begin
            key_hit = key_hit && (ring_q[0].guest_address == addr_reg[31:0]);
        end
        if (keyed_reg)
        begin
            key_hit = key_hit && (ring_q[0].key_low == klo_reg)
                   && (ring_q[0].key_high == khi_reg);
        end
    end

    always_comb
    begin
        new_entry.guest_address = host_reg ? 32'd0 : addr_reg[31:0];
        new_entry.host_handle   = host_reg ? addr_reg : 64'd0;
        new_entry.keyed         = keyed_reg;
        new_entry.key_low       = klo_reg;
        new_entry.key_high      = khi_reg;
        new_entry.width         = w_reg;
        new_entry.height        = h_reg;
        new_entry.hash          = hash_reg;
        new_entry.dirty         = 1'b0;
        new_entry.used_frame    = frame_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        frame_next      = frame_reg;
        resolved_next   = resolved_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        victim_next     = victim_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        head_mod        = ring_q[0];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (shift)
        begin
            idx_next = last_step ? '0 : idx_reg + IW'(1);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    resolved_next   = 1'b0;
                    found_next      = 1'b0;
                    idx_next        = '0;
                    res_status_next = tcache_pkg::ST_DONE;
                    res_slot_next   = '0;
                    state_next      = S_HOLD;
                    case (cmd)
                        tcache_pkg::CMD_LOOKUP:
                        begin
                            if (width == 14'd0 || height == 14'd0)
                            begin
                                res_status_next = tcache_pkg::ST_BAD_SIZE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        tcache_pkg::CMD_FRAME:
                        begin
                            if (frame_inc == 64'd0)
                            begin
                                frame_next = 64'd1;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                frame_next = frame_inc;
                            end
                        end
                        tcache_pkg::CMD_DIRTY:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_HOLD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                case (cmd_reg)
                    tcache_pkg::CMD_LOOKUP:
                    begin
                        if (!resolved_reg)
                        begin
                            if (live && key_hit)
                            begin
                                // first match in index order
                                resolved_next   = 1'b1;
                                res_slot_next   = idx_reg;
                                res_status_next = tcache_pkg::ST_HIT;
                                if (ring_q[0].dirty || ring_q[0].hash != hash_reg)
                                begin
                                    head_mod.hash   = hash_reg;
                                    head_mod.dirty  = 1'b0;
                                    res_status_next = tcache_pkg::ST_RELOAD;
                                end
                                head_mod.used_frame = frame_reg;
                            end
                            else if (CW'(idx_reg) == count_reg)
                            begin
                                // first free slot, reached only when not full
                                resolved_next   = 1'b1;
                                res_slot_next   = idx_reg;
                                res_status_next = tcache_pkg::ST_FILL;
                                head_mod        = new_entry;
                                count_next      = count_reg + CW'(1);
                            end
                            else if (live && ring_q[0].used_frame != frame_reg
                                     && (!found_reg || ring_q[0].used_frame < best_reg))
                            begin
                                found_next  = 1'b1;
                                best_next   = ring_q[0].used_frame;
                                victim_next = idx_reg;
                            end
                        end
                        if (last_step)
                        begin
                            state_next = S_HOLD;
                            if (!resolved_next)
                            begin
                                if (found_next)
                                begin
                                    res_status_next = tcache_pkg::ST_REPLACED;
                                    res_slot_next   = victim_next;
                                    state_next      = S_REPL;
                                end
                                else
                                begin
                                    res_status_next = tcache_pkg::ST_ALL_LIVE;
                                    res_slot_next   = '0;
                                end
                            end
                        end
                    end
                    tcache_pkg::CMD_FRAME:
                    begin
                        // frame wrap, clear every resident stamp
                        if (live)
                        begin
                            head_mod.used_frame = 64'd0;
                        end
                        if (last_step)
                        begin
                            state_next = S_HOLD;
                        end
                    end
                    default:
                    begin
                        // mark dirty by guest address
                        if (live && ring_q[0].guest_address == addr_reg[31:0])
                        begin
                            head_mod.dirty = 1'b1;
                        end
                        if (last_step)
                        begin
                            state_next = S_HOLD;
                        end
                    end
                endcase
            end
            S_REPL:
            begin
                if (idx_reg == victim_reg)
                begin
                    head_mod = new_entry;
                end
                if (last_step)
                begin
                    state_next = S_HOLD;
                end
            end
            default:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    slot_next      = res_slot_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            frame_reg     <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            frame_reg     <= frame_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        resolved_reg   <= resolved_next;
        found_reg      <= found_next;
        best_reg       <= best_next;
        victim_reg     <= victim_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        if (accept)
        begin
            cmd_reg   <= cmd;
            host_reg  <= is_host;
            addr_reg  <= source_address;
            w_reg     <= width;
            h_reg     <= height;
            keyed_reg <= keyed;
            klo_reg   <= key_low;
            khi_reg   <= key_high;
            hash_reg  <= content_hash;
        end
    end

    // slot field keeps the low nine bits of the index
    logic [IW+8:0] slot_wide;
    assign slot_wide = {9'd0, slot_reg};

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_wide[8:0];

endmodule

### design/tcache_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcache_cell
// one entry of the tag ring, takes its neighbor's entry on every shift
// ----------------------------------------------------------------------------
module tcache_cell
(
    input  logic              clk,
    input  logic              shift,
    input  tcache_pkg::entry_t entry_in,
    output tcache_pkg::entry_t entry_out
);

    tcache_pkg::entry_t entry_reg;

    // payload only, contents are undefined until written
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

endmodule
